// ===== hdl/sale_pkg.sv =====
`timescale 1ns / 1ps
package sale_pkg;

  typedef enum logic [2:0] {
    OP_INSERT   = 3'd0,
    OP_READ     = 3'd1,
    OP_COUNT    = 3'd2,
    OP_REMAT    = 3'd3,
    OP_REMFIRST = 3'd4,
    OP_REMALL   = 3'd5,
    OP_FIND     = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BADPOS   = 2'd2,
    ST_NOTFOUND = 2'd3
  } st_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic decide;
    logic ins_read;
    logic ins_step;
    logic ins_put;
    logic scan_read;
    logic scan_step;
    logic out_load;
  } sale_ctl_t;

  // datapath -> controller
  typedef struct packed {
    op_t  op;
    logic pre_bad;
    logic fill_zero;
    logic ins_shift;
    logic ins_last;
    logic scan_last;
    logic out_free;
  } sale_sts_t;

endpackage

// ===== hdl/sale_ctrl.sv =====
`timescale 1ns / 1ps
module sale_ctrl import sale_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  sale_sts_t sts,
  output sale_ctl_t ctl
);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_DECIDE   = 8'b0000_0010,
    S_INS_RD   = 8'b0000_0100,
    S_INS_CMP  = 8'b0000_1000,
    S_INS_PUT  = 8'b0001_0000,
    S_SCAN_RD  = 8'b0010_0000,
    S_SCAN_CMP = 8'b0100_0000,
    S_DONE     = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign req_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    ctl        = '0;
    unique case (state)
      S_IDLE: begin
        ctl.load = req_valid;
        if (req_valid) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        ctl.decide = 1'b1;
        if (sts.pre_bad) begin
          state_next = S_DONE;
        end else begin
          case (sts.op)
            OP_INSERT: state_next = sts.fill_zero ? S_INS_PUT : S_INS_RD;
            OP_COUNT, OP_REMAT, OP_REMFIRST, OP_REMALL, OP_FIND:
              state_next = sts.fill_zero ? S_DONE : S_SCAN_RD;
            default:   state_next = S_DONE;
          endcase
        end
      end
      S_INS_RD: begin
        ctl.ins_read = 1'b1;
        state_next   = S_INS_CMP;
      end
      S_INS_CMP: begin
        ctl.ins_step = 1'b1;
        state_next   = (sts.ins_shift && !sts.ins_last) ? S_INS_RD : S_INS_PUT;
      end
      S_INS_PUT: begin
        ctl.ins_put = 1'b1;
        state_next  = S_DONE;
      end
      S_SCAN_RD: begin
        ctl.scan_read = 1'b1;
        state_next    = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        ctl.scan_step = 1'b1;
        state_next    = sts.scan_last ? S_DONE : S_SCAN_RD;
      end
      S_DONE: begin
        ctl.out_load = sts.out_free;
        if (sts.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== hdl/sale_dpath.sv =====
`timescale 1ns / 1ps
module sale_dpath import sale_pkg::*; #(
  parameter int CAPACITY = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [2:0]         cmd,
  input  logic signed [31:0] value,
  input  logic [2:0]         position,
  input  sale_ctl_t          ctl,
  output sale_sts_t          sts,
  input  logic               rsp_stall,
  output logic               rsp_valid,
  output logic [1:0]         status,
  output logic signed [31:0] read_value,
  output logic [2:0]         found_position,
  output logic [3:0]         match_count
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int PW = (CW > 3) ? CW : 3;
  localparam logic [CW-1:0] CAP_W = CW'(CAPACITY);

  logic signed [31:0] mem [CAPACITY];

  op_t                op_q;
  logic signed [31:0] value_q;
  logic [2:0]         pos_q;
  logic [CW-1:0]      fill;
  logic [CW-1:0]      idx;
  logic [CW-1:0]      wj;
  logic [CW-1:0]      cnt;
  logic [IW-1:0]      first;
  logic               found;
  logic               bad_q;
  logic signed [31:0] rd_data;

  logic [CW-1:0]      idx_dec, idx_inc, wj_next;
  logic [PW-1:0]      pos_w, fill_w;
  logic               pre_bad, modify, match, drop;
  logic               we, re;
  logic [IW-1:0]      wa, ra;
  logic signed [31:0] wd;

  st_t                st_r;
  logic signed [31:0] rv_r;
  logic [2:0]         fp_r;
  logic [3:0]         mc_r;

  assign idx_dec = idx - 1'b1;
  assign idx_inc = idx + 1'b1;
  assign pos_w   = PW'(pos_q);
  assign fill_w  = PW'(fill);
  assign modify  = (op_q == OP_REMAT) || (op_q == OP_REMFIRST) || (op_q == OP_REMALL);
  assign match   = (rd_data == value_q);

  always_comb begin
    case (op_q)
      OP_INSERT:        pre_bad = (fill >= CAP_W);
      OP_READ, OP_REMAT: pre_bad = (pos_w >= fill_w);
      OP_FIND:          pre_bad = (fill == '0);
      default:          pre_bad = 1'b0;
    endcase
  end

  // entry dropped from the compacted list
  always_comb begin
    case (op_q)
      OP_REMAT:    drop = (idx == CW'(pos_q));
      OP_REMFIRST: drop = match && !found;
      OP_REMALL:   drop = match;
      default:     drop = 1'b0;
    endcase
  end

  assign wj_next = wj + CW'(!drop);

  assign sts.op        = op_q;
  assign sts.pre_bad   = pre_bad;
  assign sts.fill_zero = (fill == '0);
  assign sts.ins_shift = (value_q < rd_data);
  assign sts.ins_last  = (idx == CW'(1));
  assign sts.scan_last = (idx_inc == fill);
  assign sts.out_free  = !rsp_valid || !rsp_stall;

  // memory port selection; the command strobes are one-hot
  always_comb begin
    we = 1'b0;
    wa = idx[IW-1:0];
    wd = rd_data;
    re = 1'b0;
    ra = idx[IW-1:0];
    if (ctl.ins_step) begin
      we = sts.ins_shift;
    end else if (ctl.ins_put) begin
      we = 1'b1;
      wd = value_q;
    end else if (ctl.scan_step) begin
      we = modify && !drop;
      wa = wj[IW-1:0];
    end
    if (ctl.decide) begin
      re = (op_q == OP_READ) && !pre_bad;
      ra = IW'(pos_q);
    end else if (ctl.ins_read) begin
      re = 1'b1;
      ra = idx_dec[IW-1:0];
    end else if (ctl.scan_read) begin
      re = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (re) rd_data <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (ctl.ins_put) begin
      fill <= fill + 1'b1;
    end else if (ctl.scan_step && sts.scan_last && modify) begin
      fill <= wj_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      op_q    <= op_t'(cmd);
      value_q <= value;
      pos_q   <= position;
    end
    if (ctl.decide) begin
      bad_q <= pre_bad;
      idx   <= (op_q == OP_INSERT) ? fill : '0;
      wj    <= '0;
      cnt   <= '0;
      found <= 1'b0;
      first <= '0;
    end
    if (ctl.ins_step && sts.ins_shift) idx <= idx_dec;
    if (ctl.scan_step) begin
      idx <= idx_inc;
      wj  <= wj_next;
      if (match) begin
        cnt   <= cnt + 1'b1;
        found <= 1'b1;
        if (!found) first <= idx[IW-1:0];
      end
    end
  end

  // result word
  always_comb begin
    st_r = ST_BADPOS;
    rv_r = '0;
    fp_r = '0;
    mc_r = 4'(fill);
    case (op_q)
      OP_INSERT: begin
        if (bad_q) begin
          st_r = ST_FULL;
        end else begin
          st_r = ST_OK;
          fp_r = 3'(idx);
        end
      end
      OP_READ: begin
        if (!bad_q) begin
          st_r = ST_OK;
          rv_r = rd_data;
          fp_r = pos_q;
        end
      end
      OP_COUNT, OP_REMALL: begin
        if (found) begin
          st_r = ST_OK;
          fp_r = 3'(first);
          mc_r = 4'(cnt);
        end else begin
          st_r = ST_NOTFOUND;
          mc_r = '0;
        end
      end
      OP_REMAT: begin
        if (!bad_q) begin
          st_r = ST_OK;
          fp_r = pos_q;
        end
      end
      OP_REMFIRST: begin
        if (found) begin
          st_r = ST_OK;
          fp_r = 3'(first);
          mc_r = 4'd1;
        end else begin
          st_r = ST_NOTFOUND;
          mc_r = '0;
        end
      end
      OP_FIND: begin
        if (bad_q) begin
          mc_r = '0;
        end else if (found) begin
          st_r = ST_OK;
          fp_r = 3'(first);
        end else begin
          st_r = ST_NOTFOUND;
        end
      end
      default: st_r = ST_BADPOS;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.out_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      status         <= st_r;
      read_value     <= rv_r;
      found_position <= fp_r;
      match_count    <= mc_r;
    end
  end

endmodule

// ===== hdl/sorted_array_list_engine_unit.sv =====
`timescale 1ns / 1ps
// Sorted list of up to CAPACITY signed 32-bit values with a fill count.
// Request channel (req_valid/req_stall) carries one command word: cmd,
// value, position. Response channel (rsp_valid/rsp_stall) returns one word
// per command: status, read_value, found_position, match_count.
// A word moves on a clock edge where valid is high and stall is low.
// Read, rejected commands, unknown codes and empty-list scans skip the walk;
// insert walks down over the entries it shifts up, stopping at the front;
// count, find and remove (any form) scan every entry.
// Each entry is read through the registered read port of the entry memory,
// then compared and written back. One command is in flight at a time;
// req_stall is high from acceptance until the result is loaded, and the
// next word can be taken on the following edge.
// The result sits in an output register, so the next command is accepted
// while the previous response is still stalled; the new result waits in the
// last step until that register frees.
// Reset clears the fill count and the response valid; the entry memory is
// not cleared, and only entries below the fill count are ever read.
module sorted_array_list_engine_unit import sale_pkg::*; #(
  parameter int CAPACITY = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic [2:0]         cmd,
  input  logic signed [31:0] value,
  input  logic [2:0]         position,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output logic [1:0]         status,
  output logic signed [31:0] read_value,
  output logic [2:0]         found_position,
  output logic [3:0]         match_count
);

  sale_ctl_t ctl;
  sale_sts_t sts;

  // sequencer: decode, insert walk, compaction scan, result hand-off
  sale_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .ctl       (ctl)
  );

  // entry memory, fill count, walk indices and the response register
  sale_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .value          (value),
    .position       (position),
    .ctl            (ctl),
    .sts            (sts),
    .rsp_stall      (rsp_stall),
    .rsp_valid      (rsp_valid),
    .status         (status),
    .read_value     (read_value),
    .found_position (found_position),
    .match_count    (match_count)
  );

endmodule

// ===== hdl/sale_chk.sv =====
`timescale 1ns / 1ps
module sale_chk import sale_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_stall,
  input logic               rsp_valid,
  input logic               rsp_stall,
  input logic [1:0]         status,
  input logic signed [31:0] read_value,
  input logic [2:0]         found_position,
  input logic [3:0]         match_count
);

  // a held response keeps its word
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(status) && $stable(read_value)
      && $stable(found_position) && $stable(match_count))
    else $error("response word changed while stalled");

  // one command in flight: accepting a word closes the request side
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request accepted while a command is in flight");

  // failed commands return no data
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != ST_OK |-> read_value == 32'sd0)
    else $error("non-zero read value on a failed command");

  // reset empties the response register
  a_rst_rsp: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

endmodule

bind sorted_array_list_engine_unit sale_chk u_sale_chk (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req_valid),
  .req_stall      (req_stall),
  .rsp_valid      (rsp_valid),
  .rsp_stall      (rsp_stall),
  .status         (status),
  .read_value     (read_value),
  .found_position (found_position),
  .match_count    (match_count)
);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the sorted list engine: one command word in, one response word out.
module testbench;
  import sale_pkg::*;

  localparam int LIST_CAP = 8;
  localparam int RANDOM_WORDS = 700;
  localparam int QUIET_TAIL = 80;      // final stretch runs with no idling at all
  localparam int LONG_HOLD = 60;       // receiver hold-off, long enough to back up the input
  localparam int DRAIN_CYCLES = 40;    // quiet wait after the last reply, before the summary
  localparam logic [2:0] CMD_UNDEFINED = 3'd7;

  // Everything the engine returns for a single command.
  typedef struct packed {
    st_t                status;
    logic signed [31:0] read_value;
    logic [2:0]         found_position;
    logic [3:0]         match_count;
  } list_reply_t;

  // Shadow copy of the sorted list plus the replies it has predicted but not yet seen.
  class sorted_list_shadow;
    logic signed [31:0] slots[LIST_CAP];
    int                 fill;
    list_reply_t        replies_due[$];
    int                 errors;
    int                 commands;
    int                 replies_checked;
    int                 status_seen[4];

    function new();
      fill = 0;
      errors = 0;
      commands = 0;
      replies_checked = 0;
      foreach (status_seen[k]) status_seen[k] = 0;
    endfunction

    // First slot holding v, or fill when there is none.
    function int locate(logic signed [31:0] v);
      for (int k = 0; k < fill; k++) begin
        if (slots[k] == v) return k;
      end
      return fill;
    endfunction

    // Close the gap at p; later entries move down by one.
    function void drop_slot(int p);
      for (int k = p; k + 1 < fill; k++) slots[k] = slots[k + 1];
      if (fill > 0) fill--;
    endfunction

    // An accepted command word: update the list and queue the reply it must give.
    function void apply_command(logic [2:0] op, logic signed [31:0] operand, logic [2:0] index);
      list_reply_t r;
      int          i;
      int          j;
      int          hits;
      int          first;
      r = '0;
      r.status = ST_OK;
      first = locate(operand);
      hits = 0;
      for (i = 0; i < fill; i++) begin
        if (slots[i] == operand) hits++;
      end
      case (op)
        OP_INSERT: begin
          if (fill >= LIST_CAP) begin
            r.status = ST_FULL;
            r.match_count = 4'(fill);
          end else begin
            // equal values stay ahead of the newcomer
            i = fill;
            while (i > 0 && operand < slots[i - 1]) begin
              slots[i] = slots[i - 1];
              i--;
            end
            slots[i] = operand;
            fill++;
            r.found_position = 3'(i);
            r.match_count = 4'(fill);
          end
        end
        OP_READ: begin
          if (index >= fill) begin
            r.status = ST_BADPOS;
          end else begin
            r.read_value = slots[index];
            r.found_position = index;
          end
          r.match_count = 4'(fill);
        end
        OP_COUNT: begin
          if (hits == 0) begin
            r.status = ST_NOTFOUND;
          end else begin
            r.found_position = 3'(first);
            r.match_count = 4'(hits);
          end
        end
        OP_REMAT: begin
          if (index >= fill) begin
            r.status = ST_BADPOS;
          end else begin
            drop_slot(index);
            r.found_position = index;
          end
          r.match_count = 4'(fill);
        end
        OP_REMFIRST: begin
          if (first >= fill) begin
            r.status = ST_NOTFOUND;
          end else begin
            drop_slot(first);
            r.found_position = 3'(first);
            r.match_count = 4'd1;
          end
        end
        OP_REMALL: begin
          if (first >= fill) begin
            r.status = ST_NOTFOUND;
          end else begin
            // compact in place; every entry is looked at, shifted neighbours included
            j = 0;
            for (i = 0; i < fill; i++) begin
              if (slots[i] != operand) begin
                slots[j] = slots[i];
                j++;
              end
            end
            fill = j;
            r.found_position = 3'(first);
            r.match_count = 4'(hits);
          end
        end
        OP_FIND: begin
          if (fill == 0) begin
            r.status = ST_BADPOS;
          end else begin
            if (first >= fill) r.status = ST_NOTFOUND;
            else r.found_position = 3'(first);
            r.match_count = 4'(fill);
          end
        end
        default: begin
          r.status = ST_BADPOS;
          r.match_count = 4'(fill);
        end
      endcase
      replies_due.push_back(r);
      commands++;
    endfunction

    // A response word taken by the receiver: compare against the oldest prediction.
    function void match_reply(logic [1:0] st, logic signed [31:0] rd, logic [2:0] fp,
                              logic [3:0] mc);
      list_reply_t want;
      if (replies_due.size() == 0) begin
        $error("response word with nothing outstanding (status %0d)", st);
        errors++;
        return;
      end
      want = replies_due.pop_front();
      replies_checked++;
      status_seen[want.status]++;
      if (want.status !== st) begin
        $error("status: expected %0d, actual %0d", want.status, st);
        errors++;
      end
      if (want.read_value !== rd) begin
        $error("read_value: expected %0d, actual %0d", want.read_value, rd);
        errors++;
      end
      if (want.found_position !== fp) begin
        $error("found_position: expected %0d, actual %0d", want.found_position, fp);
        errors++;
      end
      if (want.match_count !== mc) begin
        $error("match_count: expected %0d, actual %0d", want.match_count, mc);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_stall;
  logic [2:0]         cmd = '0;
  logic signed [31:0] value = '0;
  logic [2:0]         position = '0;
  logic               rsp_valid;
  logic               rsp_stall = 1'b0;
  logic [1:0]         status;
  logic signed [31:0] read_value;
  logic [2:0]         found_position;
  logic [3:0]         match_count;

  sorted_list_shadow shadow;

  // Idling knobs for the sender and the receiver; quiet is shared by both.
  bit quiet = 1'b0;            // set for the closing stretch: no gaps, no stalls
  int gap_pct = 30;            // chance of a sender gap before a word
  int stall_pct = 30;          // chance of a receiver stall burst
  bit hold_request = 1'b0;     // asks the receiver for one long hold-off
  int hold_left = 0;
  int burst_left = 0;

  sorted_array_list_engine_unit #(.CAPACITY(LIST_CAP)) uut (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .cmd            (cmd),
    .value          (value),
    .position       (position),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .status         (status),
    .read_value     (read_value),
    .found_position (found_position),
    .match_count    (match_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offer one command word and hold it until the engine takes it. Valid stays high on
  // return, so back-to-back words never see valid dropped and raised in one step.
  task automatic issue_command(input logic [2:0] op, input logic signed [31:0] operand,
                               input logic [2:0] index);
    int gap;
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 4);
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    cmd <= op;
    value <= operand;
    position <= index;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    shadow.apply_command(op, operand, index);
  endtask

  // Receiver: take response words, then pick the stall for the next edge. A long
  // hold-off is counted here, independent of the sender, which carries on offering.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall)
      shadow.match_reply(status, read_value, found_position, match_count);
    if (hold_request) begin
      hold_left = LONG_HOLD;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else if (burst_left > 0) begin
      burst_left--;
      rsp_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
      burst_left = $urandom_range(1, 4) - 1;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  // Watchdog: a hang or lost response ends up here.
  initial begin
    #2_000_000;
    $display("sorted_array_list_engine_unit verification failed");
    $finish;
  end

  initial begin
    int                 n;
    int                 fill_now;
    int                 ins_weight;
    int                 sel;
    int                 directed;
    logic [2:0]         op;
    logic signed [31:0] operand;
    logic [2:0]         index;

    shadow = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty list first, then fill to the brim with extremes and duplicates.
    issue_command(OP_FIND, 32'sd0, 3'd0);          // find on empty list
    issue_command(OP_READ, 32'sd0, 3'd0);          // read on empty list
    issue_command(OP_REMAT, 32'sd0, 3'd0);         // remove at position on empty list
    issue_command(OP_COUNT, 32'sd5, 3'd0);         // value absent
    issue_command(OP_REMFIRST, 32'sd5, 3'd0);
    issue_command(OP_REMALL, 32'sd5, 3'd0);
    issue_command(OP_INSERT, 32'sh7fffffff, 3'd0); // largest value
    issue_command(OP_INSERT, 32'sh80000000, 3'd0); // smallest value goes to the front
    issue_command(OP_INSERT, 32'sd0, 3'd0);
    issue_command(OP_INSERT, 32'sd0, 3'd0);        // equal value lands after its twin
    issue_command(OP_INSERT, -32'sd1, 3'd0);
    issue_command(OP_INSERT, 32'sd0, 3'd0);
    issue_command(OP_INSERT, 32'sd100, 3'd0);
    issue_command(OP_INSERT, 32'sh7fffffff, 3'd0); // list now full
    issue_command(OP_INSERT, 32'sd5, 3'd0);        // refused: full
    issue_command(OP_READ, 32'sd0, 3'd7);          // last slot
    issue_command(OP_FIND, 32'sh7fffffff, 3'd0);   // match sits near the top
    issue_command(OP_COUNT, 32'sd0, 3'd0);
    issue_command(OP_REMALL, 32'sd0, 3'd0);        // adjacent duplicates all go
    issue_command(OP_REMFIRST, 32'sh7fffffff, 3'd0);
    issue_command(OP_REMAT, 32'sd0, 3'd0);
    issue_command(OP_READ, 32'sd0, 3'd6);          // beyond the fill count
    issue_command(CMD_UNDEFINED, 32'sd0, 3'd0);
    issue_command(OP_FIND, 32'sd42, 3'd0);         // absent on a non-empty list
    issue_command(OP_REMAT, 32'sd0, 3'd2);         // last entry in the list
    directed = shadow.commands;

    // Random: inserts weighted by how full the list is, so it keeps cycling through
    // empty, part-filled and full. Operands lean on a tight cluster and on values
    // already held, which makes matches and duplicates common.
    for (n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 100 == 0) begin
        gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 60);
        stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 60);
      end
      quiet = (n >= RANDOM_WORDS - QUIET_TAIL);
      if (n == 150 || n == 450) hold_request = 1'b1;

      fill_now = shadow.fill;
      ins_weight = (fill_now < 3) ? 60 : (fill_now < LIST_CAP) ? 40 : 15;
      if ($urandom_range(0, 99) < ins_weight) begin
        op = OP_INSERT;
      end else begin
        sel = $urandom_range(0, 19);
        op = (sel == 0) ? CMD_UNDEFINED : 3'(1 + sel % 6);
      end

      sel = $urandom_range(0, 9);
      if (sel < 5) begin
        operand = $signed($urandom_range(0, 8)) - 4;
      end else if (sel < 7 && fill_now > 0) begin
        operand = shadow.slots[$urandom_range(0, fill_now - 1)];
      end else if (sel == 7) begin
        case ($urandom_range(0, 3))
          0: operand = 32'sh7fffffff;
          1: operand = 32'sh80000000;
          2: operand = 32'sh7ffffffe;
          default: operand = 32'sh80000001;
        endcase
      end else begin
        operand = $urandom();
      end

      if ($urandom_range(0, 1) == 1 && fill_now > 0) index = 3'($urandom_range(0, fill_now - 1));
      else index = 3'($urandom_range(0, 7));

      issue_command(op, operand, index);
    end
    req_valid <= 1'b0;

    while (shadow.replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d command words (%0d directed), %0d response words checked",
             shadow.commands, directed, shadow.replies_checked);
    $display("statuses seen: ok %0d, full %0d, bad position %0d, not found %0d",
             shadow.status_seen[ST_OK], shadow.status_seen[ST_FULL],
             shadow.status_seen[ST_BADPOS], shadow.status_seen[ST_NOTFOUND]);
    if (shadow.errors == 0 && shadow.replies_due.size() == 0) begin
      $display("sorted_array_list_engine_unit verification clean");
    end else begin
      $display("sorted_array_list_engine_unit verification failed");
    end
    $finish;
  end

endmodule
